// ----- sv/lcsl_pkg.sv -----
package lcsl_pkg;

  localparam int SET_IDX_W = 6;
  localparam int TAG_W     = 26;
  localparam int KIND_W    = 2;
  localparam int WAY_OUT_W = 2;
  localparam int SET_CODES = 1 << SET_IDX_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT      = 2'd0,
    KIND_COLD     = 2'd1,
    KIND_CONFLICT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [WAY_OUT_W-1:0]   way;
  } lcsl_result_t;

endpackage

// ----- sv/lcsl_req_if.sv -----
interface lcsl_req_if;
  logic                          valid;
  logic                          ready;
  logic [lcsl_pkg::SET_IDX_W-1:0] set_index;
  logic [lcsl_pkg::TAG_W-1:0]     access_tag;

  modport source(output valid, output set_index, output access_tag, input ready);
  modport sink(input valid, input set_index, input access_tag, output ready);
endinterface

// ----- sv/lcsl_rsp_if.sv -----
interface lcsl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lcsl_pkg::KIND_W-1:0]    access_kind;
  logic [lcsl_pkg::WAY_OUT_W-1:0] way_used;

  modport source(output valid, output access_kind, output way_used, input ready);
  modport sink(input valid, input access_kind, input way_used, output ready);
endinterface

// ----- sv/lcsl_set_mem.sv -----
module lcsl_set_mem #(
  parameter int SETS  = 64,
  parameter int ROW_W = 120,
  localparam int SB   = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [SB-1:0]    waddr,
  input  logic [ROW_W-1:0] wdata,
  input  logic             re,
  input  logic [SB-1:0]    raddr,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/lcsl_seq.sv -----
module lcsl_seq #(
  parameter int SETS     = 64,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 26,
  localparam int SB      = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int WB      = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int ROW_W   = WAYS * TAG_BITS + WAYS + WAYS * WB
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SB-1:0]         start_set,
  input  logic [TAG_BITS-1:0]   start_tag,
  output logic                  ready,
  input  logic                  out_free,
  output logic                  push,
  output lcsl_pkg::lcsl_result_t result,
  output logic                  mem_we,
  output logic [SB-1:0]         mem_waddr,
  output logic [ROW_W-1:0]      mem_wdata,
  output logic                  mem_re,
  output logic [SB-1:0]         mem_raddr,
  input  logic [ROW_W-1:0]      mem_rdata
);
  import lcsl_pkg::*;

  // row layout: tags, then valid bits, then recency order (most recent first)
  localparam int VAL_LO = WAYS * TAG_BITS;
  localparam int ORD_LO = VAL_LO + WAYS;

  function automatic logic [ROW_W-1:0] build_reset_row();
    logic [ROW_W-1:0] r;
    r = '0;
    for (int p = 0; p < WAYS; p++) begin
      r[ORD_LO + p * WB +: WB] = WB'(p);
    end
    return r;
  endfunction

  localparam logic [ROW_W-1:0] RESET_ROW = build_reset_row();

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WALK,
    S_UPDATE
  } state_t;

  state_t              state;
  logic [SB-1:0]       clr_idx;
  logic [SB-1:0]       set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [ROW_W-1:0]    row;
  logic [WB-1:0]       pos;
  logic [WB-1:0]       target;
  logic                found;
  kind_t               kind;

  logic [WB-1:0]       cur_way;
  logic                cur_valid;
  logic [TAG_BITS-1:0] cur_tag;
  logic                is_hit;
  logic                last_pos;
  logic [WB-1:0]       sel_way;
  logic [ROW_W-1:0]    new_row;
  logic [31:0]         way32;

  // shared compare unit: one recency position per cycle
  always_comb begin
    cur_way   = row[ORD_LO + pos * WB +: WB];
    cur_valid = row[VAL_LO + cur_way];
    cur_tag   = row[cur_way * TAG_BITS +: TAG_BITS];
    is_hit    = cur_valid && (cur_tag == tag_q);
    last_pos  = (pos == WB'(WAYS - 1));
  end

  // fill chosen way and move it to the front of the recency order
  always_comb begin
    sel_way = row[ORD_LO + target * WB +: WB];
    new_row = row;
    new_row[sel_way * TAG_BITS +: TAG_BITS] = tag_q;
    new_row[VAL_LO + sel_way] = 1'b1;
    for (int p = 0; p < WAYS; p++) begin
      if (p == 0) begin
        new_row[ORD_LO +: WB] = sel_way;
      end else if (WB'(p) <= target) begin
        new_row[ORD_LO + p * WB +: WB] = row[ORD_LO + (p - 1) * WB +: WB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SB'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            set_q <= start_set;
            tag_q <= start_tag;
            state <= S_READ;
          end
        end
        S_READ: begin
          row    <= mem_rdata;
          pos    <= '0;
          found  <= 1'b0;
          kind   <= KIND_CONFLICT;
          target <= WB'(WAYS - 1);
          state  <= S_WALK;
        end
        S_WALK: begin
          if (is_hit) begin
            kind   <= KIND_HIT;
            target <= pos;
            state  <= S_UPDATE;
          end else begin
            if (!cur_valid && !found) begin
              found  <= 1'b1;
              kind   <= KIND_COLD;
              target <= pos;
            end
            if (last_pos) begin
              state <= S_UPDATE;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    way32       = 32'(sel_way);
    ready       = (state == S_IDLE);
    mem_re      = start;
    mem_raddr   = start_set;
    push        = (state == S_UPDATE) && out_free;
    mem_we      = (state == S_CLEAR) || push;
    mem_waddr   = (state == S_CLEAR) ? clr_idx : set_q;
    mem_wdata   = (state == S_CLEAR) ? RESET_ROW : new_row;
    result.kind = kind;
    result.way  = way32[WAY_OUT_W-1:0];
  end

  a_start_reads: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_READ))
    else $error("accepted request did not move to the row read");

  a_push_writes_set: assert property (@(posedge clk) disable iff (rst)
    push |-> (mem_we && (mem_waddr == set_q)))
    else $error("result issued without writing back its set");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (pos <= WB'(WAYS - 1)))
    else $error("walk position past the last way");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_CLEAR) || (state == S_UPDATE)))
    else $error("row write outside clear or update");

  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WALK) && is_hit) |=> ((state == S_UPDATE) && (kind == KIND_HIT)))
    else $error("tag match not reported as hit");

endmodule

// ----- sv/lru_cache_set_lookup_core.sv -----
// set-associative tag store with true-LRU replacement
// req channel (sink): set_index and access_tag, taken when valid and ready are high
// rsp channel (source): access_kind (hit, cold miss, conflict miss) and way_used,
// one response per request, in request order
// each request reads its set's row (tags, valid bits, recency order) from a
// single-port-write / registered-read row memory, then one shared tag comparator
// walks the ways in recency order, one way per cycle, and the updated row is
// written back when the result is pushed to the output register
// a hit ends the walk at its recency position, while misses walk all ways;
// req.ready returns with the response, so a new request is accepted only
// after the previous one has been answered
// after reset a clearing pass writes every row (all ways invalid,
// recency order 0..WAYS-1); req.ready stays low meanwhile
// the response sits in an output register: a new request is accepted while it
// waits, but if rsp.ready stays low the next write-back and response wait for it
module lru_cache_set_lookup_core #(
  parameter int SETS     = 64,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 26
) (
  input  logic       clk,
  input  logic       rst,
  lcsl_req_if.sink   req,
  lcsl_rsp_if.source rsp
);
  import lcsl_pkg::*;

  localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * TAG_BITS + WAYS + WAYS * WB;

  // set_index modulo SETS, as a constant table over all input codes
  function automatic logic [SET_CODES*SB-1:0] build_set_map();
    logic [SET_CODES*SB-1:0] m;
    int r;
    m = '0;
    r = 0;
    for (int i = 0; i < SET_CODES; i++) begin
      m[i * SB +: SB] = SB'(r);
      r = (r + 1 == SETS) ? 0 : r + 1;
    end
    return m;
  endfunction

  localparam logic [SET_CODES*SB-1:0] SET_MAP = build_set_map();

  logic                start;
  logic                seq_ready;
  logic [SB-1:0]       req_set;
  logic [31:0]         tag32;
  logic [TAG_BITS-1:0] req_tag;
  logic                out_free;
  logic                push;
  lcsl_result_t        result;
  lcsl_result_t        out_res;
  logic                out_valid;

  logic                mem_we;
  logic [SB-1:0]       mem_waddr;
  logic [ROW_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [SB-1:0]       mem_raddr;
  logic [ROW_W-1:0]    mem_rdata;

  always_comb begin
    req_set  = SET_MAP[req.set_index * SB +: SB];
    tag32    = 32'(req.access_tag);
    req_tag  = tag32[TAG_BITS-1:0];
    start    = req.valid && seq_ready;
    out_free = !out_valid || rsp.ready;
  end

  assign req.ready       = seq_ready;
  assign rsp.valid       = out_valid;
  assign rsp.access_kind = out_res.kind;
  assign rsp.way_used    = out_res.way;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= result;
    end
  end

  lcsl_seq #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_set (req_set),
    .start_tag (req_tag),
    .ready     (seq_ready),
    .out_free  (out_free),
    .push      (push),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lcsl_set_mem #(
    .SETS  (SETS),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
